// ----- design/mwpd_pkg.sv -----
// Package for the mass-weighted periodic distance block: widths, codes and
// the request/response types of the shared add/subtract unit.
// No dependencies.
`timescale 1ns / 1ps

package mwpd_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int BOX_W      = 31;
  localparam int MASS_W     = 32;
  localparam int LEN_W      = 32;
  localparam int SUM_W      = 64;
  localparam int ALU_W      = SUM_W + 1;
  localparam int CNT_W      = 6;
  localparam int AXIS_W     = 2;

  // Port widths
  localparam int IN_DATA_W  = 6 * COORD_W + MASS_W;
  localparam int OUT_DATA_W = LEN_W;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Moved mass m counts as none when m * 10^6 < 2^FRAC_BITS, i.e. m <= limit
  localparam logic [SUM_W-1:0] NO_MASS_LIMIT =
    SUM_W'(((64'd1 << FRAC_BITS) - 64'd1) / 64'd1000000);

  localparam logic [LEN_W-1:0] MOVE_CUT_RESET = LEN_W'(655);

  // Iteration counts, less one, of the shared unit
  localparam logic [CNT_W-1:0] ROOT_STEPS_M1 = CNT_W'(SUM_W / 2 - 1);
  localparam logic [CNT_W-1:0] DIV_STEPS_M1  = CNT_W'(SUM_W - 1);

  // Axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X    = 3'd0,
    CFG_BOX_Y    = 3'd1,
    CFG_BOX_Z    = 3'd2,
    CFG_THREE_D  = 3'd3,
    CFG_MOVE_CUT = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] value;
    logic             carry;   // carry out on add, borrow on subtract
  } alu_rsp_t;

endpackage

// ----- design/mwpd_alu.sv -----
// Shared 65-bit add/subtract unit used for every wide sum, root step and
// division step of the block. Depends on mwpd_pkg.
`timescale 1ns / 1ps

module mwpd_alu (
  input  mwpd_pkg::alu_req_t req,
  output mwpd_pkg::alu_rsp_t rsp
);
  import mwpd_pkg::*;

  logic [ALU_W:0] full;

  // Widen by one bit so the top bit is the carry or borrow
  always_comb begin
    unique case (req.op)
      ALU_ADD: full = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: full = {1'b0, req.a} - {1'b0, req.b};
      default: full = '0;
    endcase
  end

  assign rsp.value = full[ALU_W-1:0];
  assign rsp.carry = full[ALU_W];

endmodule

// ----- design/mass_weighted_periodic_distance.sv -----
// Top level of the mass-weighted periodic distance block: sequencer,
// configuration registers, multiplier and accumulators.
// Depends on mwpd_pkg and mwpd_alu.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata atom, tlast last_atom
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata mean, tuser flags
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// Per axis an atom is folded, then multiplied and accumulated unless it saturates;
// then come 32 square-root steps, the cut and, if it moved, the mass and weighted
// sums, all sums and steps through the one shared 65-bit add/subtract unit. The
// last atom of a set adds a no-mass check, plus 64 division steps if mass moved.
// Reset is synchronous; the result sits in an output register, so new atoms
// are taken while it waits. A second result waits until that register frees.

module mass_weighted_periodic_distance (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, atom_mass
  input  logic [mwpd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // mean_distance
  output logic [mwpd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // no_moved_mass, saturated
  output logic [mwpd_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mwpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mwpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mwpd_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_AXIS  = 11'b000_0000_0010,
    ST_MUL   = 11'b000_0000_0100,
    ST_ACC   = 11'b000_0000_1000,
    ST_ROOT  = 11'b000_0001_0000,
    ST_CUT   = 11'b000_0010_0000,
    ST_MASS  = 11'b000_0100_0000,
    ST_WSUM  = 11'b000_1000_0000,
    ST_CHECK = 11'b001_0000_0000,
    ST_DIV   = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state;

  // Configuration
  logic [BOX_W-1:0] box_x, box_y, box_z;
  logic             three_d;
  logic [LEN_W-1:0] move_cut;

  // Held atom
  logic signed [COORD_W-1:0] coord_a [3];
  logic signed [COORD_W-1:0] coord_b [3];
  logic [MASS_W-1:0]         mass;
  logic                      last;

  // Working registers
  logic [AXIS_W-1:0] axis;
  logic [LEN_W-1:0]  mag;
  logic [SUM_W-1:0]  prod;
  logic [SUM_W-1:0]  sq;
  logic [SUM_W-1:0]  work;
  logic [SUM_W-1:0]  res;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  cnt;
  logic [LEN_W-1:0]  mean;
  logic              no_mass;

  // Set accumulators
  logic [SUM_W-1:0]  wls;
  logic [SUM_W-1:0]  mms;
  logic              ovf;

  // Output register
  logic              out_valid;
  logic [LEN_W-1:0]  out_mean;
  logic              out_no_mass;
  logic              out_sat;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  mwpd_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_mean;
  assign m_axis_tuser  = {out_sat, out_no_mass};

  // Fold the difference on the current axis into the box
  logic signed [COORD_W-1:0] sel_a, sel_b;
  logic [BOX_W-1:0]          box_sel;
  logic signed [COORD_W+1:0] ax_diff, ax_fold, box_s;
  logic signed [COORD_W+2:0] ax_twice, box_w;
  logic [COORD_W+1:0]        ax_mag;
  logic                      ax_big;

  always_comb begin
    sel_a = coord_a[axis];
    sel_b = coord_b[axis];
    unique case (axis)
      AXIS_X:  box_sel = box_x;
      AXIS_Y:  box_sel = box_y;
      AXIS_Z:  box_sel = box_z;
      default: box_sel = '0;
    endcase
    box_s    = $signed({3'b000, box_sel});
    box_w    = $signed({4'b0000, box_sel});
    ax_diff  = (COORD_W+2)'(sel_b) - (COORD_W+2)'(sel_a);
    ax_twice = $signed({ax_diff, 1'b0});
    priority if (ax_twice < -box_w) ax_fold = ax_diff + box_s;
    else if (ax_twice > box_w)      ax_fold = ax_diff - box_s;
    else                            ax_fold = ax_diff;
    ax_mag = ax_fold[COORD_W+1] ? (COORD_W+2)'(-ax_fold) : (COORD_W+2)'(ax_fold);
    ax_big = (ax_mag[COORD_W+1:COORD_W] != 2'b00);
  end

  // Last axis of this atom
  logic last_axis;
  assign last_axis = (axis == AXIS_Z) || ((axis == AXIS_Y) && !three_d);

  // Root bit for the current step, and the quotient after a division step
  logic [SUM_W-1:0] root_bit;
  logic [SUM_W-1:0] quo_next;
  assign root_bit = SUM_W'(1) << {cnt[CNT_W-2:0], 1'b0};
  assign quo_next = {quo[SUM_W-2:0], ~alu_rsp.carry};

  // Saturating view of an add
  logic [SUM_W-1:0] sat_sum;
  assign sat_sum = alu_rsp.value[SUM_W] ? '1 : alu_rsp.value[SUM_W-1:0];

  // Output register loads from the final state once it is free
  logic out_load;
  assign out_load = (state == ST_DONE) && (!out_valid || m_axis_tready);

  // Select the operands of the shared unit for each step
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state)
      ST_ACC: begin
        alu_req.a = {1'b0, sq};
        alu_req.b = {1'b0, prod};
      end
      ST_ROOT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {1'b0, work};
        alu_req.b  = {1'b0, res | root_bit};
      end
      ST_MASS: begin
        alu_req.a = {1'b0, mms};
        alu_req.b = ALU_W'(mass);
      end
      ST_WSUM: begin
        alu_req.a = {1'b0, wls};
        alu_req.b = {1'b0, prod};
      end
      ST_DIV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {work, quo[SUM_W-1]};
        alu_req.b  = {1'b0, mms};
      end
      default: begin
      end
    endcase
  end

  // Multiplier operands: squared magnitude, or mass times length
  logic [LEN_W-1:0] mul_x, mul_y;
  assign mul_x = (state == ST_CUT) ? mass : mag;
  assign mul_y = (state == ST_CUT) ? res[LEN_W-1:0] : mag;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      box_x    <= '0;
      box_y    <= '0;
      box_z    <= '0;
      three_d  <= 1'b1;
      move_cut <= MOVE_CUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BOX_X:    box_x    <= cfg_data[BOX_W-1:0];
        CFG_BOX_Y:    box_y    <= cfg_data[BOX_W-1:0];
        CFG_BOX_Z:    box_z    <= cfg_data[BOX_W-1:0];
        CFG_THREE_D:  three_d  <= cfg_data[0];
        CFG_MOVE_CUT: move_cut <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold the atom on transfer
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      coord_a[0] <= s_axis_tdata[0*COORD_W +: COORD_W];
      coord_a[1] <= s_axis_tdata[1*COORD_W +: COORD_W];
      coord_a[2] <= s_axis_tdata[2*COORD_W +: COORD_W];
      coord_b[0] <= s_axis_tdata[3*COORD_W +: COORD_W];
      coord_b[1] <= s_axis_tdata[4*COORD_W +: COORD_W];
      coord_b[2] <= s_axis_tdata[5*COORD_W +: COORD_W];
      mass       <= s_axis_tdata[6*COORD_W +: MASS_W];
      last       <= s_axis_tlast;
    end
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    if (state == ST_MUL || state == ST_CUT) begin
      prod <= mul_x * mul_y;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wls       <= '0;
      mms       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once it is taken, unless a new one replaces it
      if (out_valid && m_axis_tready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            axis  <= AXIS_X;
            sq    <= '0;
            state <= ST_AXIS;
          end
        end

        ST_AXIS: begin
          mag <= ax_mag[LEN_W-1:0];
          if (ax_big) begin
            // Axis beyond 32 bits: saturate the sum of squares
            sq  <= '1;
            ovf <= 1'b1;
            if (last_axis) begin
              work  <= '1;
              res   <= '0;
              cnt   <= ROOT_STEPS_M1;
              state <= ST_ROOT;
            end else begin
              axis  <= axis + AXIS_W'(1);
            end
          end else begin
            state <= ST_MUL;
          end
        end

        ST_MUL: begin
          state <= ST_ACC;
        end

        ST_ACC: begin
          sq <= sat_sum;
          if (alu_rsp.value[SUM_W]) begin
            ovf <= 1'b1;
          end
          if (last_axis) begin
            work  <= sat_sum;
            res   <= '0;
            cnt   <= ROOT_STEPS_M1;
            state <= ST_ROOT;
          end else begin
            axis  <= axis + AXIS_W'(1);
            state <= ST_AXIS;
          end
        end

        // One bit of the integer square root per cycle
        ST_ROOT: begin
          if (!alu_rsp.carry) begin
            work <= alu_rsp.value[SUM_W-1:0];
            res  <= (res >> 1) | root_bit;
          end else begin
            res  <= res >> 1;
          end
          if (cnt == '0) begin
            state <= ST_CUT;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end

        ST_CUT: begin
          if (res[LEN_W-1:0] > move_cut) begin
            state <= ST_MASS;
          end else if (last) begin
            state <= ST_CHECK;
          end else begin
            state <= ST_IDLE;
          end
        end

        ST_MASS: begin
          mms <= sat_sum;
          if (alu_rsp.value[SUM_W]) begin
            ovf <= 1'b1;
          end
          state <= ST_WSUM;
        end

        ST_WSUM: begin
          wls <= sat_sum;
          if (alu_rsp.value[SUM_W]) begin
            ovf <= 1'b1;
          end
          state <= last ? ST_CHECK : ST_IDLE;
        end

        ST_CHECK: begin
          if (mms <= NO_MASS_LIMIT) begin
            mean    <= '0;
            no_mass <= 1'b1;
            state   <= ST_DONE;
          end else begin
            work  <= '0;
            quo   <= wls;
            cnt   <= DIV_STEPS_M1;
            state <= ST_DIV;
          end
        end

        // One quotient bit per cycle, restoring division
        ST_DIV: begin
          if (!alu_rsp.carry) begin
            work <= alu_rsp.value[SUM_W-1:0];
          end else begin
            work <= {work[SUM_W-2:0], quo[SUM_W-1]};
          end
          quo <= quo_next;
          if (cnt == '0) begin
            no_mass <= 1'b0;
            if (quo_next[SUM_W-1:LEN_W] != '0) begin
              mean <= '1;
              ovf  <= 1'b1;
            end else begin
              mean <= quo_next[LEN_W-1:0];
            end
            state <= ST_DONE;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end

        // Load the output register once it is free, then clear the set
        ST_DONE: begin
          if (out_load) begin
            out_valid   <= 1'b1;
            out_mean    <= mean;
            out_no_mass <= no_mass;
            out_sat     <= ovf;
            wls         <= '0;
            mms         <= '0;
            ovf         <= 1'b0;
            state       <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/mwpd_checker.sv -----
// Port-level checks for the mass-weighted periodic distance block, bound to
// the top level. Depends on mwpd_pkg.
`timescale 1ns / 1ps

module mwpd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mwpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [mwpd_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import mwpd_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // An accepted atom keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after a transfer");

  // A set with no moved mass reports a zero distance
  a_no_mass: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("non-zero distance with no moved mass");

  // A new result follows a busy cycle
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a busy cycle");

endmodule

bind mass_weighted_periodic_distance mwpd_checker u_mwpd_checker (.*);

// ----- dv/mwpd_displacement_checker.sv -----
// Checker for the mass-weighted periodic distance block: watches the atom,
// result and configuration channels, predicts each set's mean and compares.
// Depends on mwpd_pkg.
`timescale 1ns / 1ps

module mwpd_displacement_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, atom_mass
  input  logic [mwpd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tlast,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // mean_distance
  input  logic [mwpd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // no_moved_mass, saturated
  input  logic [mwpd_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [mwpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mwpd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                outstanding,
  output int                                mismatches
);
  import mwpd_pkg::*;

  localparam int WIDE_W = 2 * SUM_W;

  typedef struct packed {
    logic [LEN_W-1:0] mean;
    logic             no_mass;
    logic             sat;
  } mean_result_t;

  // Configuration copy
  logic [BOX_W-1:0] box_x, box_y, box_z;
  logic             three_d;
  logic [LEN_W-1:0] cut;

  // Running set state
  logic [SUM_W-1:0] weighted_sum;
  logic [SUM_W-1:0] mass_sum;
  logic             sat_seen;

  mean_result_t mean_q [$];

  initial mismatches = 0;

  task automatic log_mismatch(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Add with saturation at all ones, flagging the set
  function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[SUM_W]) begin
      sat_seen = 1'b1;
      return '1;
    end
    return s[SUM_W-1:0];
  endfunction

  // Fold one axis into the box and add its square to the running sum
  function automatic logic [SUM_W-1:0] add_axis_square(input logic [SUM_W-1:0] acc,
                                                       input logic [COORD_W-1:0] from_pos,
                                                       input logic [COORD_W-1:0] to_pos,
                                                       input logic [BOX_W-1:0] box);
    longint d, span;
    logic [SUM_W-1:0] mag;
    d = longint'($signed(to_pos)) - longint'($signed(from_pos));
    span = longint'({1'b0, box});
    if (2 * d < -span) begin
      d = d + span;
    end else if (2 * d > span) begin
      d = d - span;
    end
    mag = (d < 0) ? -d : d;
    if (mag > SUM_W'({LEN_W{1'b1}})) begin
      sat_seen = 1'b1;
      return '1;
    end
    return add_sat(acc, mag * mag);
  endfunction

  // Largest r with r*r <= v, one bit at a time from the top
  function automatic logic [LEN_W-1:0] floor_root(input logic [SUM_W-1:0] v);
    logic [LEN_W-1:0] r, trial;
    r = '0;
    for (int i = LEN_W - 1; i >= 0; i--) begin
      trial = r | (LEN_W'(1) << i);
      if (SUM_W'(trial) * SUM_W'(trial) <= v) r = trial;
    end
    return r;
  endfunction

  // Take one atom into the set; on the last atom produce the mean and clear
  function automatic bit absorb_atom(input logic [IN_DATA_W-1:0] atom, input logic last,
                                     output mean_result_t res);
    logic [SUM_W-1:0]  sq, quot;
    logic [LEN_W-1:0]  len;
    logic [MASS_W-1:0] mass;
    logic              none;
    res = '0;
    sq = '0;
    sq = add_axis_square(sq, atom[0*COORD_W +: COORD_W], atom[3*COORD_W +: COORD_W], box_x);
    sq = add_axis_square(sq, atom[1*COORD_W +: COORD_W], atom[4*COORD_W +: COORD_W], box_y);
    if (three_d) begin
      sq = add_axis_square(sq, atom[2*COORD_W +: COORD_W], atom[5*COORD_W +: COORD_W], box_z);
    end
    len = floor_root(sq);
    mass = atom[6*COORD_W +: MASS_W];
    if (len > cut) begin
      mass_sum = add_sat(mass_sum, SUM_W'(mass));
      weighted_sum = add_sat(weighted_sum, SUM_W'(mass) * SUM_W'(len));
    end
    if (!last) return 1'b0;

    // Moved mass counts as none when mass * 10^6 < 1.0 in fixed point
    none = (WIDE_W'(mass_sum) * WIDE_W'(1000000)) < (WIDE_W'(1) << FRAC_BITS);
    if (!none) begin
      quot = weighted_sum / mass_sum;
      if (quot > SUM_W'({LEN_W{1'b1}})) begin
        quot = SUM_W'({LEN_W{1'b1}});
        sat_seen = 1'b1;
      end
      res.mean = quot[LEN_W-1:0];
    end
    res.no_mass = none;
    res.sat = sat_seen;
    weighted_sum = '0;
    mass_sum = '0;
    sat_seen = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    mean_result_t want, fresh;
    if (rst) begin
      box_x = '0;
      box_y = '0;
      box_z = '0;
      three_d = 1'b1;
      cut = MOVE_CUT_RESET;
      weighted_sum = '0;
      mass_sum = '0;
      sat_seen = 1'b0;
      mean_q.delete();
    end else begin
      // Compare each result transfer with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (mean_q.size() == 0) begin
          log_mismatch("result with none pending, mean_distance", 64'(m_axis_tdata),
                       64'(0));
        end else begin
          want = mean_q.pop_front();
          if (m_axis_tdata !== want.mean)
            log_mismatch("mean_distance", 64'(m_axis_tdata), 64'(want.mean));
          if (m_axis_tuser[0] !== want.no_mass)
            log_mismatch("no_moved_mass", 64'(m_axis_tuser[0]), 64'(want.no_mass));
          if (m_axis_tuser[1] !== want.sat)
            log_mismatch("saturated", 64'(m_axis_tuser[1]), 64'(want.sat));
        end
      end

      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_BOX_X:    box_x = cfg_data[BOX_W-1:0];
          CFG_BOX_Y:    box_y = cfg_data[BOX_W-1:0];
          CFG_BOX_Z:    box_z = cfg_data[BOX_W-1:0];
          CFG_THREE_D:  three_d = cfg_data[0];
          CFG_MOVE_CUT: cut = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end

      // Predict from each atom transfer
      if (s_axis_tvalid && s_axis_tready) begin
        if (absorb_atom(s_axis_tdata, s_axis_tlast, fresh)) mean_q.push_back(fresh);
      end
    end
    outstanding <= mean_q.size();
  end

endmodule

// ----- dv/mass_weighted_periodic_distance_tb.sv -----
// Testbench top for the mass-weighted periodic distance block: drives atoms
// and register writes, stalls the result side and gives the verdict.
// Depends on mwpd_pkg, mass_weighted_periodic_distance and mwpd_displacement_checker.
`timescale 1ns / 1ps

module mass_weighted_periodic_distance_tb;
  import mwpd_pkg::*;

  localparam int SETTLE_CYCLES   = 150;
  localparam int QUIET_LIMIT     = 4000;
  localparam int PHASES          = 9;
  localparam int ATOMS_PER_PHASE = 128;

  typedef struct {
    logic [COORD_W-1:0] from_x, from_y, from_z;
    logic [COORD_W-1:0] to_x, to_y, to_z;
    logic [MASS_W-1:0]  mass;
    logic               last;
  } atom_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int outstanding;
  int mismatches;

  // Settings currently loaded, used to shape positions
  logic [BOX_W-1:0] box_now [3] = '{'0, '0, '0};
  logic [LEN_W-1:0] cut_now = MOVE_CUT_RESET;

  int burst_left   = 1;
  int stall_left   = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  mass_weighted_periodic_distance DUT (.*);

  mwpd_displacement_checker checker_i (.*);

  // Result side: runs of ready, runs of stall and choppy stretches
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          m_axis_tready <= 1'b1;
          stall_left <= $urandom_range(20, 80);
        end
        1: begin
          m_axis_tready <= 1'b0;
          stall_left <= $urandom_range(1, 30);
        end
        default: begin
          m_axis_tready <= 1'($urandom_range(0, 1));
          stall_left <= $urandom_range(0, 4);
        end
      endcase
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Uniform value in [-reach, reach]
  function automatic logic [31:0] spread(input longint reach);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return 32'(longint'(raw % 64'(2 * reach + 1)) - reach);
  endfunction

  // Atom displaced by (dx, dy, dz) from a random spot near the origin
  function automatic atom_t moved(input int dx, input int dy, input int dz,
                                  input logic [31:0] mass, input logic last);
    atom_t a;
    a.from_x = spread(1 << 20);
    a.from_y = spread(1 << 20);
    a.from_z = spread(1 << 20);
    a.to_x = a.from_x + 32'(dx);
    a.to_y = a.from_y + 32'(dy);
    a.to_z = a.from_z + 32'(dz);
    a.mass = mass;
    a.last = last;
    return a;
  endfunction

  // Atom with the same start and end word on every axis
  function automatic atom_t span_atom(input logic [31:0] from_pos, input logic [31:0] to_pos,
                                      input logic [31:0] mass, input logic last);
    atom_t a;
    a.from_x = from_pos;
    a.from_y = from_pos;
    a.from_z = from_pos;
    a.to_x = to_pos;
    a.to_y = to_pos;
    a.to_z = to_pos;
    a.mass = mass;
    a.last = last;
    return a;
  endfunction

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] random_mass();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return 32'($urandom_range(0, 65535));
      4, 5: return $urandom;
      default: return (32'($urandom_range(1, 200)) << FRAC_BITS) | 32'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly plausible motion inside the box, some wrap-arounds and some noise
  function automatic atom_t random_atom(input logic last);
    atom_t a;
    logic [31:0] from_pos [3];
    logic [31:0] to_pos [3];
    longint span, near;
    int shape;
    near = longint'(cut_now) * 2 + 64;
    if (near > 64'sd2147483647) near = 64'sd2147483647;
    shape = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      span = longint'(box_now[k]);
      if (span > 0 && $urandom_range(0, 4) != 0) begin
        from_pos[k] = 32'($urandom_range(0, box_now[k]));
      end else begin
        from_pos[k] = spread(1 << 24);
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: to_pos[k] = from_pos[k] + spread(near);
        8, 9, 10: to_pos[k] = from_pos[k] + spread(span > 0 ? span / 2 + 1 : 1 << 20);
        11, 12, 13: to_pos[k] = from_pos[k] + spread(near) +
                                ($urandom_range(0, 1) ? 32'(span) : -32'(span));
        14, 15: to_pos[k] = from_pos[k];
        16, 17: begin
          from_pos[k] = $urandom;
          to_pos[k] = $urandom;
        end
        default: begin
          from_pos[k] = extreme_word();
          to_pos[k] = extreme_word();
        end
      endcase
    end
    // Whole atoms at rest, or moved by about the cut along x alone
    if (shape == 0) begin
      to_pos = from_pos;
    end else if (shape == 1) begin
      to_pos[0] = from_pos[0] + cut_now + spread(1);
      to_pos[1] = from_pos[1];
      to_pos[2] = from_pos[2];
    end
    a.from_x = from_pos[0];
    a.from_y = from_pos[1];
    a.from_z = from_pos[2];
    a.to_x = to_pos[0];
    a.to_y = to_pos[1];
    a.to_z = to_pos[2];
    a.mass = random_mass();
    a.last = last;
    return a;
  endfunction

  function automatic logic [31:0] random_box();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 32'd1;
      2: return 32'($urandom_range(2, 64));
      3, 4: return 32'($urandom_range(10, 200)) << FRAC_BITS;
      5: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_cut();
    case ($urandom_range(0, 7))
      0: return '0;
      1, 2: return 32'(MOVE_CUT_RESET);
      3: return 32'($urandom_range(0, 1 << FRAC_BITS));
      4, 5: return 32'($urandom_range(0, 8)) << FRAC_BITS;
      6: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one atom, hold until transferred, then pace the bursts
  task automatic send_atom(input atom_t a);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {a.mass, a.to_z, a.to_y, a.to_x, a.from_z, a.from_y, a.from_x};
    s_axis_tlast  <= a.last;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, 120))
        @(posedge clk);
    end
  endtask

  // Stop sending, wait for every pending result, then let the block go idle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write every register once while the block is idle
  task automatic load_config(input logic [31:0] bx, input logic [31:0] by,
                             input logic [31:0] bz, input logic td, input logic [31:0] cut);
    cfg_reg_t    order [5];
    logic [31:0] value [5];
    order = '{CFG_BOX_X, CFG_BOX_Y, CFG_BOX_Z, CFG_THREE_D, CFG_MOVE_CUT};
    value = '{bx, by, bz, {31'($urandom), td}, cut};
    drain_results();
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= value[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    box_now = '{bx[BOX_W-1:0], by[BOX_W-1:0], bz[BOX_W-1:0]};
    cut_now = cut;
  endtask

  // Random whole sets, mostly short, sometimes long
  task automatic send_sets(input int atoms);
    int sent, set_len;
    sent = 0;
    while (sent < atoms) begin
      set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
      for (int i = 1; i <= set_len; i++) send_atom(random_atom(i == set_len));
      sent += set_len;
      // now and then hold off until every result is back
      if ($urandom_range(0, 15) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: no box, 3-D, cut of about 0.01
    send_atom(moved(0, 0, 0, 32'h0001_0000, 1'b1));
    send_atom(moved(655, 0, 0, 32'h0001_0000, 1'b0));
    send_atom(moved(656, 0, 0, 32'h0001_0000, 1'b1));
    send_atom(moved(0, 0, -700, 32'h0003_0000, 1'b1));
    send_atom(moved(3000, 4000, 0, 32'd1, 1'b1));
    send_atom(moved(1000, 0, 0, 32'd0, 1'b1));
    send_atom(span_atom(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_atom(span_atom(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_atom(span_atom(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 1'b1));
    send_atom(span_atom(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));

    // Odd and even tiny boxes, 2-D, zero cut: exact half-box folding
    load_config(32'd11, 32'd10, 32'hFFFF_FFFF, 1'b0, 32'd0);
    send_atom(moved(5, 5, 0, 32'h0001_0000, 1'b1));
    send_atom(moved(6, 6, 123456, 32'h0001_0000, 1'b1));
    send_atom(moved(-6, -5, 0, 32'h0001_0000, 1'b1));
    send_atom(moved(-5, -6, -99, 32'h0002_0000, 1'b0));
    send_atom(moved(0, 0, 0, 32'h0001_0000, 1'b1));

    // Largest boxes and cut: nothing is ever counted
    load_config('1, '1, '1, 1'b1, '1);
    send_sets(ATOMS_PER_PHASE / 2);

    // No box at all, 2-D, zero cut
    load_config('0, '0, '0, 1'b0, '0);
    send_sets(ATOMS_PER_PHASE);

    for (int p = 0; p < PHASES; p++) begin
      load_config(random_box(), random_box(), random_box(), 1'($urandom_range(0, 1)),
                  random_cut());
      send_sets(ATOMS_PER_PHASE);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
